// File: rtl/core/afbu_pkg.sv
// ============================================================================
// afbu_pkg
// Shared types and operation codes of the ALU, flags and branch unit.
// ============================================================================
package afbu_pkg;

    localparam int unsigned DataWidth = 16;
    localparam int unsigned FuncWidth = 6;
    localparam int unsigned FlagWidth = 4;
    localparam int unsigned OffWidth  = 8;

    // flag bit positions
    localparam int unsigned FlagN = 3;
    localparam int unsigned FlagZ = 2;
    localparam int unsigned FlagV = 1;
    localparam int unsigned FlagC = 0;

    typedef enum logic [FuncWidth-1:0] {
        FN_CLR  = 6'd0,
        FN_CLRB = 6'd1,
        FN_COM  = 6'd2,
        FN_COMB = 6'd3,
        FN_INC  = 6'd4,
        FN_INCB = 6'd5,
        FN_DEC  = 6'd6,
        FN_DECB = 6'd7,
        FN_NEG  = 6'd8,
        FN_NEGB = 6'd9,
        FN_TST  = 6'd10,
        FN_TSTB = 6'd11,
        FN_MOV  = 6'd12,
        FN_MOVB = 6'd13,
        FN_CMP  = 6'd14,
        FN_CMPB = 6'd15,
        FN_ADD  = 6'd16,
        FN_SUB  = 6'd17,
        FN_BR   = 6'd18,
        FN_BNE  = 6'd19,
        FN_BEQ  = 6'd20,
        FN_BGE  = 6'd21,
        FN_BLT  = 6'd22,
        FN_BGT  = 6'd23,
        FN_BLE  = 6'd24,
        FN_BPL  = 6'd25,
        FN_BMI  = 6'd26,
        FN_BHI  = 6'd27,
        FN_BLOS = 6'd28,
        FN_BVC  = 6'd29,
        FN_BVS  = 6'd30,
        FN_BCC  = 6'd31,
        FN_BCS  = 6'd32
    } func_t;

    typedef struct packed {
        logic [FuncWidth-1:0] func;
        logic [DataWidth-1:0] src_value;
        logic [DataWidth-1:0] dst_value;
        logic                 dst_is_register;
        logic [DataWidth-1:0] pc_value;
        logic [OffWidth-1:0]  branch_offset;
    } in_word_t;

    typedef struct packed {
        logic [DataWidth-1:0] result_value;
        logic                 write_back;
        logic [FlagWidth-1:0] flags_out;
        logic                 branch_taken;
        logic [DataWidth-1:0] next_pc;
    } out_word_t;

    // data path status, ALU to top
    typedef struct packed {
        logic [DataWidth-1:0] result_value;
        logic                 write_back;
        logic [FlagWidth-1:0] flags;
    } alu_out_t;

    // branch status, branch unit to top
    typedef struct packed {
        logic                 taken;
        logic [DataWidth-1:0] target;
    } br_out_t;

endpackage

// File: rtl/core/alu_flags_and_branch_unit.sv
// ============================================================================
// alu_flags_and_branch_unit
// Sixteen-bit ALU with N/Z/V/C flags and a conditional branch evaluator.
// ============================================================================
//
//  channel | valid         | ready         | word
//  --------+---------------+---------------+----------------------------
//  item    | item_valid    | item_ready    | item   (in_word_t)
//  result  | result_valid  | result_ready  | result (out_word_t)
//
//  A word lands in the input register, the ALU and branch logic
//  evaluate it against the flag register, and the outcome is loaded
//  into the result register. One word per cycle is sustained unless stalled.
//  The flag register is the only feedback and updates when a word moves
//  from the input register to the result register, so consecutive words
//  see each other's flags without a bubble.
//  Reset clears both valid bits and the flags. A stalled result holds the
//  input register; item_ready stays high while the input register can drain.
//
module alu_flags_and_branch_unit
    import afbu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  in_word_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_word_t result
);

    // input stage
    in_word_t             item_reg;
    logic                 item_valid_reg;
    logic                 item_valid_next;

    // output stage
    out_word_t            result_reg;
    out_word_t            result_next;
    logic                 result_valid_reg;
    logic                 result_valid_next;

    // held condition flags
    logic [FlagWidth-1:0] flags_reg;
    logic [FlagWidth-1:0] flags_next;

    logic                 accept;
    logic                 advance;   // input stage moves into result stage

    alu_out_t             alu_out;
    br_out_t              br_out;

    afbu_alu u_alu (
        .func            (item_reg.func),
        .src_value       (item_reg.src_value),
        .dst_value       (item_reg.dst_value),
        .dst_is_register (item_reg.dst_is_register),
        .flags_in        (flags_reg),
        .alu_out         (alu_out)
    );

    afbu_branch u_branch (
        .func          (item_reg.func),
        .flags_in      (flags_reg),
        .pc_value      (item_reg.pc_value),
        .branch_offset (item_reg.branch_offset),
        .br_out        (br_out)
    );

    assign advance    = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || advance;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        item_valid_next   = accept || (item_valid_reg && !advance);
        result_valid_next = advance || (result_valid_reg && !result_ready);
        flags_next        = advance ? alu_out.flags : flags_reg;

        result_next.result_value = alu_out.result_value;
        result_next.write_back   = alu_out.write_back;
        result_next.flags_out    = alu_out.flags;
        result_next.branch_taken = br_out.taken;
        result_next.next_pc      = br_out.target;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            flags_reg        <= '0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
            flags_reg        <= flags_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: rtl/core/afbu_alu.sv
// ============================================================================
// afbu_alu
// Word and byte data operations with N/Z/V/C flag generation.
// ============================================================================
module afbu_alu
    import afbu_pkg::*;
(
    input  logic [FuncWidth-1:0] func,
    input  logic [DataWidth-1:0] src_value,
    input  logic [DataWidth-1:0] dst_value,
    input  logic                 dst_is_register,
    input  logic [FlagWidth-1:0] flags_in,
    output alu_out_t             alu_out
);

    logic                 c_old;
    logic [DataWidth-1:0] s;
    logic [DataWidth-1:0] d;
    logic [7:0]           sb;
    logic [7:0]           db;
    logic [7:0]           lo;
    logic [DataWidth-1:0] res;
    logic [DataWidth:0]   sum;      // s + d with carry
    logic [DataWidth:0]   diff_sd;  // s - d with borrow
    logic [DataWidth:0]   diff_ds;  // d - s with borrow
    logic [8:0]           diffb;    // byte s - d with borrow

    function automatic logic [1:0] nz16(input logic [DataWidth-1:0] r);
        nz16 = {r[DataWidth-1], (r == '0)};
    endfunction

    function automatic logic [1:0] nz8(input logic [7:0] r);
        nz8 = {r[7], (r == 8'h00)};
    endfunction

    assign c_old   = flags_in[FlagC];
    assign s       = src_value;
    assign d       = dst_value;
    assign sb      = src_value[7:0];
    assign db      = dst_value[7:0];
    assign sum     = {1'b0, s} + {1'b0, d};
    assign diff_sd = {1'b0, s} - {1'b0, d};
    assign diff_ds = {1'b0, d} - {1'b0, s};
    assign diffb   = {1'b0, sb} - {1'b0, db};

    always_comb
    begin
        alu_out.result_value = '0;
        alu_out.write_back   = 1'b0;
        alu_out.flags        = flags_in;
        lo                   = '0;
        res                  = '0;
        case (func)
            FN_CLR:
            begin
                alu_out.write_back = 1'b1;
                alu_out.flags      = 4'b0100;
            end
            FN_CLRB:
            begin
                alu_out.result_value = {s[15:8], 8'h00};
                alu_out.write_back   = 1'b1;
                alu_out.flags        = 4'b0100;
            end
            FN_COM:
            begin
                res                  = ~s;
                alu_out.result_value = res;
                alu_out.write_back   = 1'b1;
                alu_out.flags        = {nz16(res), 1'b0, 1'b1};
            end
            FN_COMB:
            begin
                lo                   = ~sb;
                alu_out.result_value = {s[15:8], lo};
                alu_out.write_back   = 1'b1;
                alu_out.flags        = {nz8(lo), 1'b0, 1'b1};
            end
            FN_INC:
            begin
                res                  = s + 16'd1;
                alu_out.result_value = res;
                alu_out.write_back   = 1'b1;
                alu_out.flags        = {nz16(res), (res == 16'h8000), c_old};
            end
            FN_INCB:
            begin
                lo                   = sb + 8'd1;
                alu_out.result_value = {s[15:8], lo};
                alu_out.write_back   = 1'b1;
                alu_out.flags        = {nz8(lo), (lo == 8'h80), c_old};
            end
            FN_DEC:
            begin
                res                  = s - 16'd1;
                alu_out.result_value = res;
                alu_out.write_back   = 1'b1;
                alu_out.flags        = {nz16(res), (res == 16'h7fff), c_old};
            end
            FN_DECB:
            begin
                lo                   = sb - 8'd1;
                alu_out.result_value = {s[15:8], lo};
                alu_out.write_back   = 1'b1;
                alu_out.flags        = {nz8(lo), (lo == 8'h7f), c_old};
            end
            FN_NEG:
            begin
                res                  = 16'd0 - s;
                alu_out.result_value = res;
                alu_out.write_back   = 1'b1;
                alu_out.flags        = {nz16(res), (res == 16'h8000), (res != 16'd0)};
            end
            FN_NEGB:
            begin
                lo                   = 8'd0 - sb;
                alu_out.result_value = {s[15:8], lo};
                alu_out.write_back   = 1'b1;
                alu_out.flags        = {nz8(lo), (lo == 8'h80), (lo != 8'd0)};
            end
            FN_TST:
            begin
                alu_out.flags = {nz16(s), 2'b00};
            end
            FN_TSTB:
            begin
                alu_out.flags = {nz8(sb), 2'b00};
            end
            FN_MOV:
            begin
                alu_out.result_value = s;
                alu_out.write_back   = 1'b1;
                alu_out.flags        = {nz16(s), 1'b0, c_old};
            end
            FN_MOVB:
            begin
                // register destination takes the sign-extended byte
                alu_out.result_value = dst_is_register ? {{8{sb[7]}}, sb}
                                                       : {d[15:8], sb};
                alu_out.write_back   = 1'b1;
                alu_out.flags        = {nz8(sb), 1'b0, c_old};
            end
            FN_CMP:
            begin
                res           = diff_sd[15:0];
                alu_out.flags = {nz16(res),
                                 ((s[15] ^ d[15]) & ~(res[15] ^ d[15])),
                                 diff_sd[16]};
            end
            FN_CMPB:
            begin
                lo            = diffb[7:0];
                alu_out.flags = {nz8(lo),
                                 ((sb[7] ^ db[7]) & ~(lo[7] ^ db[7])),
                                 diffb[8]};
            end
            FN_ADD:
            begin
                res                  = sum[15:0];
                alu_out.result_value = res;
                alu_out.write_back   = 1'b1;
                alu_out.flags        = {nz16(res),
                                        (~(s[15] ^ d[15]) & (res[15] ^ d[15])),
                                        sum[16]};
            end
            FN_SUB:
            begin
                // dst minus src
                res                  = diff_ds[15:0];
                alu_out.result_value = res;
                alu_out.write_back   = 1'b1;
                alu_out.flags        = {nz16(res),
                                        ((s[15] ^ d[15]) & ~(res[15] ^ s[15])),
                                        diff_ds[16]};
            end
            default:
            begin
                // branches and unused codes keep the held flags
                alu_out.flags = flags_in;
            end
        endcase
    end

endmodule

// File: rtl/core/afbu_branch.sv
// ============================================================================
// afbu_branch
// Branch condition test on the held flags and target address adder.
// ============================================================================
module afbu_branch
    import afbu_pkg::*;
(
    input  logic [FuncWidth-1:0] func,
    input  logic [FlagWidth-1:0] flags_in,
    input  logic [DataWidth-1:0] pc_value,
    input  logic [OffWidth-1:0]  branch_offset,
    output br_out_t              br_out
);

    logic                 n;
    logic                 z;
    logic                 v;
    logic                 c;
    logic                 cond;
    logic [DataWidth-1:0] disp;

    assign n = flags_in[FlagN];
    assign z = flags_in[FlagZ];
    assign v = flags_in[FlagV];
    assign c = flags_in[FlagC];

    // word offset, sign extended and doubled
    assign disp = {{(DataWidth-OffWidth-1){branch_offset[OffWidth-1]}}, branch_offset, 1'b0};

    always_comb
    begin
        case (func)
            FN_BR:   cond = 1'b1;
            FN_BNE:  cond = ~z;
            FN_BEQ:  cond = z;
            FN_BGE:  cond = ~(n ^ v);
            FN_BLT:  cond = n ^ v;
            FN_BGT:  cond = ~(z | (n ^ v));
            FN_BLE:  cond = z | (n ^ v);
            FN_BPL:  cond = ~n;
            FN_BMI:  cond = n;
            FN_BHI:  cond = ~(c | z);
            FN_BLOS: cond = c | z;
            FN_BVC:  cond = ~v;
            FN_BVS:  cond = v;
            FN_BCC:  cond = ~c;
            FN_BCS:  cond = c;
            default: cond = 1'b0;
        endcase
    end

    assign br_out.taken  = cond;
    assign br_out.target = cond ? (pc_value + disp) : pc_value;

endmodule
